### sv/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store: opcodes, widths
// and the command that is broadcast along the row of entry cells.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int ILS_CAPACITY     = 64;
    localparam int ILS_MAX_CAPACITY = 1024;
    localparam int ILS_DATA_W       = 32;
    localparam int ILS_POS_W        = 16;
    localparam int ILS_OP_W         = 3;
    localparam int ILS_SLOT_W       = $clog2(ILS_MAX_CAPACITY + 1);
    localparam int ILS_GROUP        = 32;

    localparam logic [ILS_OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [ILS_OP_W-1:0] OP_FRONT  = 3'd1;
    localparam logic [ILS_OP_W-1:0] OP_BACK   = 3'd2;
    localparam logic [ILS_OP_W-1:0] OP_AT     = 3'd3;
    localparam logic [ILS_OP_W-1:0] OP_DELETE = 3'd4;

    localparam logic [ILS_DATA_W-1:0] MISS_VALUE = '1;

    // Command seen by every cell in the cycle an item is accepted
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic [ILS_SLOT_W-1:0]   slot;
        logic [ILS_DATA_W-1:0]   value;
    } cell_cmd_t;

endpackage

### sv/ils_cmd_if.sv
// ----------------------------------------------------------------------------
// ils_cmd_if
// Command channel of the indexed list store: valid/ready and one item.
// ----------------------------------------------------------------------------
interface ils_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  opcode;
    logic signed [15:0]          position;
    logic signed [31:0]          item_value;

    modport source (output valid, output opcode, output position, output item_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input item_value,
                    output ready);
endinterface

### sv/ils_rsp_if.sv
// ----------------------------------------------------------------------------
// ils_rsp_if
// Result channel of the indexed list store: valid/ready and one item.
// ----------------------------------------------------------------------------
interface ils_rsp_if #(
    parameter int CNT_W = 7
);
    logic                        valid;
    logic                        ready;
    logic signed [31:0]          read_data;
    logic                        hit;
    logic                        accepted;
    logic [CNT_W-1:0]            entry_count;

    modport source (output valid, output read_data, output hit, output accepted,
                    output entry_count, input ready);
    modport sink   (input valid, input read_data, input hit, input accepted,
                    input entry_count, output ready);
endinterface

### sv/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// One list position. Takes the left neighbour's entry when an insert lands
// ahead of it, the right neighbour's when a delete lands at or ahead of it,
// and drives its entry onto the read tap when the slot names it.
// ----------------------------------------------------------------------------
module ils_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  ils_pkg::cell_cmd_t            cmd,
    input  logic [ils_pkg::ILS_DATA_W-1:0] left_data,
    input  logic [ils_pkg::ILS_DATA_W-1:0] right_data,
    output logic [ils_pkg::ILS_DATA_W-1:0] entry,
    output logic [ils_pkg::ILS_DATA_W-1:0] read_tap
);
    import ils_pkg::*;

    localparam logic [ILS_SLOT_W-1:0] MY_IDX = ILS_SLOT_W'(IDX);

    logic [ILS_DATA_W-1:0] entry_reg;
    logic [ILS_DATA_W-1:0] entry_next;

    // Choose the shift source for this position
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (MY_IDX > cmd.slot)
                entry_next = left_data;
            else if (MY_IDX == cmd.slot)
                entry_next = cmd.value;
        end
        else if (cmd.del)
        begin
            if (MY_IDX >= cmd.slot)
                entry_next = right_data;
        end
    end

    // Hold the entry; payload needs no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign read_tap = (MY_IDX == cmd.slot) ? entry_reg : '0;

endmodule

### sv/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of
// cells, with read, front/back/positional insert and delete by position.
// ----------------------------------------------------------------------------
// The block accepts one command item per clock while the result stages are
// not held by a stalled result port, and returns exactly one result item per
// command. Inserts and deletes shift the entries from the addressed slot
// upward in the accepting cycle, so a command may follow the previous one at
// once. On the read path the cell taps are ORed into groups of 32 and
// registered, then the groups are combined into the result register. A full
// store drops an insert and reports accepted low. Entries need no clearing
// after reset; the count alone decides which positions are valid.
module indexed_list_store_core #(
    parameter int CAPACITY = ils_pkg::ILS_CAPACITY
) (
    input  logic         clk,
    input  logic         rst_n,
    ils_cmd_if.sink      cmd,
    ils_rsp_if.source    rsp
);
    import ils_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NGRP  = (CAPACITY + ILS_GROUP - 1) / ILS_GROUP;
    localparam int NPAD  = NGRP * ILS_GROUP;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [ILS_DATA_W-1:0] pend_grp_reg [NGRP];
    logic [ILS_DATA_W-1:0] pend_grp_next [NGRP];
    logic                  pend_hit_reg, pend_hit_next;
    logic                  pend_acc_reg, pend_acc_next;
    logic [CNT_W-1:0]      pend_cnt_reg, pend_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ILS_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_hit_reg, out_hit_next;
    logic                  out_acc_reg, out_acc_next;
    logic [CNT_W-1:0]      out_cnt_reg, out_cnt_next;

    logic                  in_fire, out_free, pend_adv;
    logic                  pos_neg, full, in_range, at_ok;
    logic                  do_ins, do_del, do_read;
    logic [ILS_POS_W-1:0]  count_ext;
    logic [ILS_SLOT_W-1:0] slot;
    logic [ILS_DATA_W-1:0] grp_or;
    cell_cmd_t             cell_cmd;

    logic [ILS_DATA_W-1:0] entries [CAPACITY];
    logic [ILS_DATA_W-1:0] taps [NPAD];

    // Handshake between the two result stages
    assign out_free  = !out_valid_reg || rsp.ready;
    assign pend_adv  = pend_valid_reg && out_free;
    assign cmd.ready = !pend_valid_reg || out_free;
    assign in_fire   = cmd.valid && cmd.ready;

    // Decode the command against the current count
    assign pos_neg   = cmd.position[ILS_POS_W-1];
    assign count_ext = ILS_POS_W'(count_reg);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign in_range  = !pos_neg && (cmd.position < $signed(count_ext));
    assign at_ok     = pos_neg || (cmd.position <= $signed(count_ext));

    always_comb
    begin
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_read = 1'b0;
        slot    = ILS_SLOT_W'(cmd.position);
        unique case (cmd.opcode)
            OP_READ:
            begin
                do_read = in_range;
            end
            OP_FRONT:
            begin
                do_ins = !full;
                slot   = '0;
            end
            OP_BACK:
            begin
                do_ins = !full;
                slot   = ILS_SLOT_W'(count_reg);
            end
            OP_AT:
            begin
                do_ins = !full && at_ok;
                if (pos_neg)
                    slot = '0;
            end
            OP_DELETE:
            begin
                do_del = in_range;
            end
            default:
            begin
                do_ins = 1'b0;
            end
        endcase
    end

    assign cell_cmd.ins   = in_fire && do_ins;
    assign cell_cmd.del   = in_fire && do_del;
    assign cell_cmd.slot  = slot;
    assign cell_cmd.value = cmd.item_value;

    // Row of entry cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            ils_cell #(
                .IDX (gi)
            ) u_cell (
                .clk        (clk),
                .cmd        (cell_cmd),
                .left_data  ((gi == 0) ? entries[0] : entries[(gi == 0) ? 0 : gi - 1]),
                .right_data (entries[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .entry      (entries[gi]),
                .read_tap   (taps[gi])
            );
        end
        for (gi = CAPACITY; gi < NPAD; gi++)
        begin : g_pad
            assign taps[gi] = '0;
        end
    endgenerate

    // Fold the taps of each group of cells
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            pend_grp_next[g] = '0;
            for (int j = 0; j < ILS_GROUP; j++)
                pend_grp_next[g] = pend_grp_next[g] | taps[g * ILS_GROUP + j];
        end
    end

    // Next count and first result stage
    always_comb
    begin
        count_next = count_reg;
        if (cell_cmd.ins)
            count_next = count_reg + CNT_W'(1);
        else if (cell_cmd.del)
            count_next = count_reg - CNT_W'(1);
        pend_valid_next = in_fire ? 1'b1 : (pend_adv ? 1'b0 : pend_valid_reg);
        pend_hit_next   = do_read;
        pend_acc_next   = do_ins || do_del;
        pend_cnt_next   = count_next;
    end

    // Combine the groups into the result stage
    always_comb
    begin
        grp_or = '0;
        for (int g = 0; g < NGRP; g++)
            grp_or = grp_or | pend_grp_reg[g];
        out_valid_next = pend_adv ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
        out_data_next  = pend_hit_reg ? grp_or : MISS_VALUE;
        out_hit_next   = pend_hit_reg;
        out_acc_next   = pend_acc_reg;
        out_cnt_next   = pend_cnt_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload: load stage one on accept, stage two on advance
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_grp_reg <= pend_grp_next;
            pend_hit_reg <= pend_hit_next;
            pend_acc_reg <= pend_acc_next;
            pend_cnt_reg <= pend_cnt_next;
        end
        if (pend_adv)
        begin
            out_data_reg <= out_data_next;
            out_hit_reg  <= out_hit_next;
            out_acc_reg  <= out_acc_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.accepted    = out_acc_reg;
    assign rsp.entry_count = out_cnt_reg;

    // Checks
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_hit_acc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.accepted))
        else $error("result both hit and accepted");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        cell_cmd.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count");

    a_stall_pend: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (pend_valid_reg && out_valid_reg && !rsp.ready))
        else $error("command stalled without a waiting result");

endmodule

### test/indexed_list_store_core_test.sv
// ----------------------------------------------------------------------------
// indexed_list_store_core_test
// Self-checking bench for the indexed list store. Commands go in through the
// command channel with random gaps, and results are drained with random
// stalls. A scoreboard keeps its own copy of the list, works out each result
// as a command is taken, and compares every returned item field by field.
// ----------------------------------------------------------------------------
module indexed_list_store_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ils_pkg::*;

    localparam int CNT_W        = $clog2(ILS_CAPACITY + 1);
    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_ITEMS   = 250;

    // Opcodes that the block must treat as no-ops
    localparam logic [ILS_OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [ILS_OP_W-1:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [ILS_OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    // Traffic shapes for the random part
    typedef enum int { MODE_GROW, MODE_SHRINK, MODE_MIXED } traffic_mode_e;

    typedef struct packed {
        logic [ILS_DATA_W-1:0] read_data;
        logic                  hit;
        logic                  accepted;
        logic [CNT_W-1:0]      entry_count;
    } list_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: list shadow plus queue of results still owed by the block
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic [ILS_DATA_W-1:0] entries [ILS_CAPACITY];
        int unsigned           count;
        list_result_t          owed_q [$];
        int unsigned           errors;

        function new();
            count  = 0;
            errors = 0;
            foreach (entries[i]) entries[i] = '0;
        endfunction

        // Store value before slot, shifting the tail up; 0 when refused
        function logic place_entry(int unsigned slot, logic [ILS_DATA_W-1:0] value);
            if (count >= ILS_CAPACITY || slot > count)
                return 1'b0;
            for (int i = int'(count); i > int'(slot); i--)
                entries[i] = entries[i-1];
            entries[slot] = value;
            count++;
            return 1'b1;
        endfunction

        // Apply one accepted command and queue the result it should give
        function void note_command(logic [ILS_OP_W-1:0] op, logic signed [ILS_POS_W-1:0] pos,
                                   logic [ILS_DATA_W-1:0] value);
            list_result_t r;
            int           p;
            p             = pos;
            r.read_data   = MISS_VALUE;
            r.hit         = 1'b0;
            r.accepted    = 1'b0;
            case (op)
                OP_READ:
                    if (p >= 0 && p < int'(count))
                    begin
                        r.read_data = entries[p];
                        r.hit       = 1'b1;
                    end
                OP_FRONT:
                    r.accepted = place_entry(0, value);
                OP_BACK:
                    r.accepted = place_entry(count, value);
                OP_AT:
                    if (p < 0)
                        r.accepted = place_entry(0, value);
                    else if (p <= int'(count))
                        r.accepted = place_entry(p, value);
                OP_DELETE:
                    if (p >= 0 && p < int'(count))
                    begin
                        for (int i = p; i < int'(count) - 1; i++)
                            entries[i] = entries[i+1];
                        count--;
                        r.accepted = 1'b1;
                    end
                default: ;
            endcase
            r.entry_count = CNT_W'(count);
            owed_q.push_back(r);
        endfunction

        // Compare a returned item with the oldest owed result
        function void check_result(list_result_t got);
            list_result_t want;
            if (owed_q.size() == 0)
            begin
                $display("%0t: result item with none outstanding: data %h hit %b acc %b cnt %0d",
                         $time, got.read_data, got.hit, got.accepted, got.entry_count);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $display("%0t: read_data expected %h, got %h", $time,
                         want.read_data, got.read_data);
                errors++;
            end
            if (got.hit !== want.hit)
            begin
                $display("%0t: hit expected %b, got %b", $time, want.hit, got.hit);
                errors++;
            end
            if (got.accepted !== want.accepted)
            begin
                $display("%0t: accepted expected %b, got %b", $time,
                         want.accepted, got.accepted);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $display("%0t: entry_count expected %0d, got %0d", $time,
                         want.entry_count, got.entry_count);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    logic stall_on;

    ils_cmd_if              cmd_ch ();
    ils_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

    list_scoreboard sb = new();

    indexed_list_store_core #(
        .CAPACITY (ILS_CAPACITY)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Clock, 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hold the command channel idle with noise on the fields
    task automatic idle_cmd(int unsigned n);
        cmd_ch.valid      <= 1'b0;
        cmd_ch.opcode     <= ILS_OP_W'($urandom);
        cmd_ch.position   <= ILS_POS_W'($urandom);
        cmd_ch.item_value <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    // Offer one item and hold it until taken, then note it
    task automatic send_cmd(logic [ILS_OP_W-1:0] op, logic signed [ILS_POS_W-1:0] pos,
                            logic [ILS_DATA_W-1:0] value);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.position   <= pos;
        cmd_ch.item_value <= value;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.note_command(op, pos, value);
    endtask

    // Insert an idle burst now and then, unless in the calm tail
    task automatic send_cmd_gap(logic idle_on);
        if (!calm && idle_on && $urandom_range(0, 5) == 0)
            idle_cmd($urandom_range(1, 14));
    endtask

    // Pick a position: mostly in range, some at the edges, some anywhere
    function automatic logic signed [ILS_POS_W-1:0] pick_position(logic for_insert);
        int unsigned roll;
        int          top;
        roll = $urandom_range(0, 99);
        top  = for_insert ? int'(sb.count) : int'(sb.count) - 1;
        if (roll < 78 && top >= 0)
            return ILS_POS_W'($urandom_range(0, top));
        else if (roll < 90)
            return ILS_POS_W'(int'(sb.count) + int'($urandom_range(0, 2)) - 1);
        else if (roll < 94)
            return ILS_POS_W'(-int'($urandom_range(1, 4)));
        else
            return ILS_POS_W'($urandom);
    endfunction

    // Pick a value, leaning on the extremes now and then
    function automatic logic [ILS_DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return MISS_VALUE;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Check each returned item as it is taken
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result({rsp_ch.read_data, rsp_ch.hit, rsp_ch.accepted,
                             rsp_ch.entry_count});
    end

    // Result side: ready in runs, broken by stall bursts
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!calm && stall_on)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    // Reset, directed commands, random commands, drain and verdict
    initial
    begin
        traffic_mode_e         mode;
        logic                  idle_on;
        logic [ILS_OP_W-1:0]   op;
        logic [ILS_DATA_W-1:0] value;
        int unsigned           roll;
        int unsigned           guard;

        rst_n             = 1'b0;
        calm              = 1'b0;
        stall_on          = 1'b1;
        idle_on           = 1'b1;
        mode              = MODE_GROW;
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = OP_READ;
        cmd_ch.position   = '0;
        cmd_ch.item_value = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store: reads and deletes miss, insert past the count is ignored
        send_cmd(OP_READ, 16'sd0, '0);
        send_cmd(OP_READ, -16'sd1, '0);
        send_cmd(OP_DELETE, 16'sd0, '0);
        send_cmd(OP_AT, 16'sd1, 32'h1234_5678);
        // Negative positional insert lands at the front
        send_cmd(OP_AT, 16'sh8000, 32'h7FFF_FFFF);
        send_cmd(OP_FRONT, 16'sd0, 32'h8000_0000);
        send_cmd(OP_BACK, 16'sh7FFF, MISS_VALUE);
        send_cmd(OP_AT, 16'sd3, 32'h0000_0000);
        send_cmd(OP_AT, 16'sd1, 32'hA5A5_5A5A);
        send_cmd(OP_AT, 16'sd0, 32'h5A5A_A5A5);
        send_cmd(OP_AT, 16'sd7, 32'hDEAD_BEEF);
        // Reads at both ends, just past the end and at the position extremes
        send_cmd(OP_READ, 16'sd0, '0);
        send_cmd(OP_READ, 16'sd5, '0);
        send_cmd(OP_READ, 16'sd6, '0);
        send_cmd(OP_READ, 16'sh7FFF, '0);
        send_cmd(OP_READ, 16'sh8000, '0);
        // Deletes out of range, in the middle, at the front and at the back
        send_cmd(OP_DELETE, -16'sd1, '0);
        send_cmd(OP_DELETE, 16'sh7FFF, '0);
        send_cmd(OP_DELETE, 16'sd6, '0);
        send_cmd(OP_DELETE, 16'sd2, '0);
        send_cmd(OP_DELETE, 16'sd0, '0);
        send_cmd(OP_DELETE, 16'sd3, '0);
        // Spare opcodes change nothing
        send_cmd(OP_UNUSED_FIRST, 16'sd0, 32'hFFFF_0000);
        send_cmd(OP_UNUSED_MID, -16'sd1, 32'h0000_FFFF);
        send_cmd(OP_UNUSED_LAST, 16'sd1, 32'hFFFF_FFFF);

        // Random part in phases that fill, drain or churn the store
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 120 == 0)
            begin
                mode     = traffic_mode_e'($urandom_range(0, 2));
                idle_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;

            roll = $urandom_range(0, 99);
            case (mode)
                MODE_GROW:   roll = (roll < 70) ? 0 : (roll < 85) ? 1 : (roll < 96) ? 2 : 3;
                MODE_SHRINK: roll = (roll < 15) ? 0 : (roll < 35) ? 1 : (roll < 96) ? 2 : 3;
                default:     roll = (roll < 40) ? 0 : (roll < 70) ? 1 : (roll < 96) ? 2 : 3;
            endcase
            value = pick_value();
            case (roll)
                0:
                begin
                    op = ILS_OP_W'($urandom_range(OP_FRONT, OP_AT));
                    send_cmd_gap(idle_on);
                    send_cmd(op, (op == OP_AT) ? pick_position(1'b1)
                                               : ILS_POS_W'($urandom), value);
                end
                1:
                begin
                    send_cmd_gap(idle_on);
                    send_cmd(OP_READ, pick_position(1'b0), value);
                end
                2:
                begin
                    send_cmd_gap(idle_on);
                    send_cmd(OP_DELETE, pick_position(1'b0), value);
                end
                default:
                begin
                    op = ILS_OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
                    send_cmd_gap(idle_on);
                    send_cmd(op, ILS_POS_W'($urandom), value);
                end
            endcase
        end

        // Drain: wait for every owed result, then give the verdict
        cmd_ch.valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("indexed_list_store_core_test passed");
        else
            $display("indexed_list_store_core_test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("indexed_list_store_core_test failed");
        $finish;
    end

endmodule
